FILE: src/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
`default_nettype none
package ffha_pkg;
  localparam int FW   = 27;      // width of offsets and sizes
  localparam int SZ_W = FW + 1;  // padded request may exceed the field width
  localparam int DEF_MAX_BLOCKS      = 1024;
  localparam int DEF_MIN_BLOCK_BYTES = 64;
  localparam int DEF_HEADER_BYTES    = 12;
  localparam logic [FW-1:0] LIMIT_RESET = FW'(104857600);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // one heap block: offset, size with header, free mark
  typedef struct packed {
    logic [FW-1:0] off;
    logic [FW-1:0] size;
    logic          fr;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic [FW-1:0] user;
    status_t       status;
    logic [FW-1:0] heap;
  } res_t;
endpackage
`default_nettype wire

FILE: src/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/ffha_ctrl.sv
// Allocator sequencer: scans, splits, merges and shifts the block table.
// Depends on ffha_pkg and ffha_ram.
`default_nettype none
module ffha_ctrl import ffha_pkg::*; #(
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
  parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
  parameter int HEADER_BYTES    = DEF_HEADER_BYTES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cmd_t          cmd,
  input  wire logic [FW-1:0] request_size,
  input  wire logic [FW-1:0] free_offset,
  input  wire logic [FW-1:0] heap_limit,
  output logic               in_ready,
  output logic               res_valid,
  input  wire logic          res_ready,
  output res_t               res
);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BLOCKS);
  localparam logic [SZ_W-1:0]  HDR  = SZ_W'(HEADER_BYTES);
  localparam logic [SZ_W-1:0]  MINB = SZ_W'(MIN_BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCHK, S_APP, S_URD, S_UWR, S_SPLW, S_NRD, S_NCHK,
    S_DRD, S_DWR, S_FIN
  } state_t;

  state_t           state;
  cmd_t             cmd_r;
  logic [SZ_W-1:0]  need;
  logic [FW-1:0]    addr_r;
  logic [CNT_W-1:0] idx, j, count, bidx;
  logic [1:0]       k;
  logic [FW-1:0]    heap_top;
  ent_t             prev, cur, bent;
  logic             prv_ok, pm;
  logic [FW-1:0]    res_user;
  status_t          res_st;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  ent_t             wdata, rdata;
  logic [ENT_W-1:0] rdata_raw;

  ffha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = ent_t'(rdata_raw);

  // scan-stage decodes
  logic [SZ_W-1:0]  req_pad, rest;
  logic             fit, split, match, last, pfree;
  logic [CNT_W-1:0] idx1;
  always_comb begin
    req_pad = {1'b0, request_size} + HDR;
    rest    = {1'b0, rdata.size} - need;
    fit     = rdata.fr && ({1'b0, rdata.size} >= need);
    split   = (rest >= MINB) && (count < MAXC);
    match   = !rdata.fr && (({1'b0, rdata.off} + HDR) == {1'b0, addr_r});
    idx1    = idx + CNT_W'(1);
    last    = (idx1 == count);
    pfree   = prv_ok && prev.fr;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx[IDX_W-1:0];
    wdata = rdata;
    raddr = idx[IDX_W-1:0];
    unique case (state)
      S_SCHK: begin
        if (cmd_r == CMD_ALLOC && fit) begin
          we = 1'b1;
          wdata.fr = 1'b0;
          if (split) wdata.size = need[FW-1:0];
        end
      end
      S_APP: begin
        waddr = count[IDX_W-1:0];
        wdata = '{off: heap_top, size: need[FW-1:0], fr: 1'b0};
        we = ({2'b0, heap_top} + {1'b0, need} <= {2'b0, heap_limit}) && (count < MAXC);
      end
      S_URD: raddr = j[IDX_W-1:0];
      S_UWR: begin
        we = 1'b1;
        waddr = IDX_W'(j + CNT_W'(1));
      end
      S_SPLW: begin
        we = 1'b1;
        waddr = IDX_W'(idx + CNT_W'(1));
        wdata = '{off: cur.off + need[FW-1:0], size: cur.size - need[FW-1:0], fr: 1'b1};
      end
      S_NRD: raddr = IDX_W'(idx + CNT_W'(1));
      S_NCHK: begin
        we = 1'b1;
        waddr = bidx[IDX_W-1:0];
        wdata = bent;
        if (rdata.fr) wdata.size = bent.size + rdata.size;
      end
      S_DRD: raddr = IDX_W'(j + CNT_W'(k));
      S_DWR: begin
        we = 1'b1;
        waddr = j[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      heap_top <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          cmd_r    <= cmd;
          addr_r   <= free_offset;
          need     <= (req_pad < MINB) ? MINB : req_pad;
          idx      <= '0;
          prv_ok   <= 1'b0;
          res_user <= '0;
          res_st   <= ST_OK;
          if (count == '0) begin
            state <= (cmd == CMD_ALLOC) ? S_APP : S_FIN;
            if (cmd == CMD_FREE) res_st <= ST_UNKNOWN;
          end else begin
            state <= S_SRD;
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (cmd_r == CMD_ALLOC) begin
            if (fit) begin
              cur      <= rdata;
              res_user <= rdata.off + FW'(HEADER_BYTES);
              if (split) begin
                j     <= count - CNT_W'(1);
                state <= last ? S_SPLW : S_URD;
              end else begin
                state <= S_FIN;
              end
            end else begin
              idx   <= idx1;
              state <= last ? S_APP : S_SRD;
            end
          end else if (match) begin
            // base block after merging with a free predecessor
            pm   <= pfree;
            bidx <= pfree ? idx - CNT_W'(1) : idx;
            bent <= '{off: pfree ? prev.off : rdata.off,
                      size: pfree ? prev.size + rdata.size : rdata.size, fr: 1'b1};
            if (last) begin
              heap_top <= pfree ? prev.off : rdata.off;
              count    <= count - (pfree ? CNT_W'(2) : CNT_W'(1));
              state    <= S_FIN;
            end else begin
              state <= S_NRD;
            end
          end else begin
            prev   <= rdata;
            prv_ok <= 1'b1;
            idx    <= idx1;
            if (last) begin
              res_st <= ST_UNKNOWN;
              state  <= S_FIN;
            end else begin
              state <= S_SRD;
            end
          end
        end
        S_APP: begin
          if ({2'b0, heap_top} + {1'b0, need} > {2'b0, heap_limit}) begin
            res_st <= ST_LIMIT;
          end else if (count >= MAXC) begin
            res_st <= ST_FULL;
          end else begin
            res_user <= heap_top + FW'(HEADER_BYTES);
            heap_top <= heap_top + need[FW-1:0];
            count    <= count + CNT_W'(1);
          end
          state <= S_FIN;
        end
        S_URD: state <= S_UWR;
        S_UWR: begin
          if (j == idx1) begin
            state <= S_SPLW;
          end else begin
            j     <= j - CNT_W'(1);
            state <= S_URD;
          end
        end
        S_SPLW: begin
          count <= count + CNT_W'(1);
          state <= S_FIN;
        end
        S_NRD: state <= S_NCHK;
        S_NCHK: begin
          logic [1:0] kk;
          kk = rdata.fr ? (pm ? 2'd2 : 2'd1) : (pm ? 2'd1 : 2'd0);
          k <= kk;
          j <= bidx + CNT_W'(1);
          if (kk == 2'd0) begin
            state <= S_FIN;
          end else if (bidx + CNT_W'(1) + CNT_W'(kk) < count) begin
            state <= S_DRD;
          end else begin
            count <= count - CNT_W'(kk);
            state <= S_FIN;
          end
        end
        S_DRD: state <= S_DWR;
        S_DWR: begin
          j <= j + CNT_W'(1);
          if (j + CNT_W'(1) + CNT_W'(k) < count) begin
            state <= S_DRD;
          end else begin
            count <= count - CNT_W'(k);
            state <= S_FIN;
          end
        end
        S_FIN: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign res       = '{user: res_user, status: res_st, heap: heap_top};
endmodule
`default_nettype wire

FILE: src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: stream ports, limit register,
// output register. Depends on ffha_pkg, ffha_ctrl, ffha_ram.
//
//  group  dir  payload
//  s_*    in   tuser: cmd; tdata: request_size, free_offset
//  m_*    out  tuser: status; tdata: user_offset, heap_size
//  cfg_*  in   heap_limit write
//
// One word at a time. An allocate scans the table entry by entry up to the
// first fit, or appends a block at the heap top if none fits; a split then
// shifts the entries above the fit up one place. A free scans to the block,
// checks the next one, then shifts the entries above it down. Reset gives an
// empty heap at once.
// A result waiting in the output register lets one more word in; that word's
// result then holds the input off until the first is taken.
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
  parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
  parameter int HEADER_BYTES    = DEF_HEADER_BYTES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [55:0]   s_tdata,   // request_size, free_offset, zero pad
  input  wire logic          s_tuser,   // cmd
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [55:0]        m_tdata,   // user_offset, heap_size, zero pad
  output logic [1:0]         m_tuser,   // status
  input  wire logic          cfg_wen,
  input  wire logic [FW-1:0] cfg_wdata
);
  logic [FW-1:0] heap_limit;
  logic          res_valid, res_ready;
  res_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= LIMIT_RESET;
    end else if (cfg_wen) begin
      heap_limit <= cfg_wdata;
    end
  end

  ffha_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS), .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .start(s_tvalid && s_tready),
    .cmd(cmd_t'(s_tuser)),
    .request_size(s_tdata[FW-1:0]),
    .free_offset(s_tdata[2*FW-1:FW]),
    .heap_limit(heap_limit),
    .in_ready(s_tready),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign res_ready = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      m_tdata <= {2'b00, res.heap, res.user};
      m_tuser <= res.status;
    end
  end
endmodule
`default_nettype wire

FILE: sim/first_fit_heap_allocator_tb.sv
// Testbench for first_fit_heap_allocator: directed and random allocate/free words,
// checked against an in-bench first-fit heap predictor. Depends on ffha_pkg and the RTL.
`default_nettype none
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = DEF_MAX_BLOCKS;
  localparam int MINB = DEF_MIN_BLOCK_BYTES;
  localparam int HDR  = DEF_HEADER_BYTES;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_wen = 1'b0;
  logic [FW-1:0] cfg_wdata = '0;

  first_fit_heap_allocator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // heap model
  logic [FW-1:0] blk_off [NBLK];
  logic [FW-1:0] blk_size [NBLK];
  bit blk_free [NBLK];
  int blk_cnt;
  logic [FW-1:0] heap_top;
  logic [FW-1:0] limit_reg;
  res_t pending_res [$];
  logic [FW-1:0] live_users [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_rx = 1'b0;

  task automatic tbl_insert(int at, logic [FW-1:0] o, logic [FW-1:0] s, bit f);
    for (int k = blk_cnt; k > at; k--) begin
      blk_off[k] = blk_off[k-1]; blk_size[k] = blk_size[k-1]; blk_free[k] = blk_free[k-1];
    end
    blk_off[at] = o; blk_size[at] = s; blk_free[at] = f;
    blk_cnt++;
  endtask

  task automatic tbl_remove(int at);
    for (int k = at; k < blk_cnt - 1; k++) begin
      blk_off[k] = blk_off[k+1]; blk_size[k] = blk_size[k+1]; blk_free[k] = blk_free[k+1];
    end
    blk_cnt--;
  endtask

  task automatic predict_heap(cmd_t c, logic [FW-1:0] req, logic [FW-1:0] addr);
    res_t r;
    logic [SZ_W:0] need;
    int i;
    bit done;
    r.user = '0;
    r.status = ST_OK;
    done = 1'b0;
    if (c == CMD_ALLOC) begin
      need = {2'b0, req} + (SZ_W+1)'(HDR);
      if (need < (SZ_W+1)'(MINB)) need = (SZ_W+1)'(MINB);
      for (i = 0; i < blk_cnt && !done; i++) begin
        if (blk_free[i] && blk_size[i] >= need) begin
          if (blk_size[i] - need >= MINB && blk_cnt < NBLK) begin
            tbl_insert(i + 1, FW'(blk_off[i] + need), FW'(blk_size[i] - need), 1'b1);
            blk_size[i] = need[FW-1:0];
          end
          blk_free[i] = 1'b0;
          r.user = FW'(blk_off[i] + HDR);
          done = 1'b1;
        end
      end
      if (!done) begin
        if (heap_top + need > limit_reg) r.status = ST_LIMIT;
        else if (blk_cnt >= NBLK) r.status = ST_FULL;
        else begin
          tbl_insert(blk_cnt, heap_top, need[FW-1:0], 1'b0);
          r.user = FW'(heap_top + HDR);
          heap_top = FW'(heap_top + need);
        end
      end
      if (r.status == ST_OK) live_users.push_back(r.user);
    end else begin
      for (i = 0; i < blk_cnt; i++)
        if (!blk_free[i] && blk_off[i] + HDR == addr) break;
      if (i >= blk_cnt) r.status = ST_UNKNOWN;
      else begin
        foreach (live_users[k]) if (live_users[k] == addr) begin
          live_users.delete(k);
          break;
        end
        blk_free[i] = 1'b1;
        if (i > 0 && blk_free[i-1]) begin
          blk_size[i-1] += blk_size[i];
          tbl_remove(i);
          i--;
        end
        if (i + 1 == blk_cnt) begin
          heap_top = blk_off[i];
          tbl_remove(i);
        end else if (blk_free[i+1]) begin
          blk_size[i] += blk_size[i+1];
          tbl_remove(i + 1);
        end
      end
    end
    r.heap = heap_top;
    pending_res.push_back(r);
  endtask

  task automatic send_word(cmd_t c, logic [FW-1:0] req, logic [FW-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {2'b0, addr, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_heap(c, req, addr);
    @(negedge clk);
    s_tvalid <= 1'b0;
    // ready stays low after an accept
    @(negedge clk);
  endtask

  task automatic alloc_word(logic [FW-1:0] req);
    send_word(CMD_ALLOC, req, FW'($urandom));
  endtask

  task automatic free_word(logic [FW-1:0] addr);
    send_word(CMD_FREE, FW'($urandom), addr);
  endtask

  task automatic drain();
    while (pending_res.size() != 0) @(negedge clk);
    repeat (4200) @(negedge clk);
  endtask

  task automatic write_limit(logic [FW-1:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    limit_reg = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic free_all();
    while (live_users.size() != 0) free_word(live_users[$urandom_range(live_users.size()-1)]);
  endtask

  always @(negedge clk) m_tready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result user=%0d status=%0d heap=%0d", $time,
                 m_tdata[26:0], m_tuser, m_tdata[53:27]);
        errors++;
      end else begin
        exp_r = pending_res.pop_front();
        if (m_tdata[26:0] !== exp_r.user || m_tuser !== exp_r.status ||
            m_tdata[53:27] !== exp_r.heap || m_tdata[55:54] !== 2'b0) begin
          $display("%0t: mismatch expected user=%0d status=%0d heap=%0d",
                   $time, exp_r.user, exp_r.status, exp_r.heap,
                   ", actual user=%0d status=%0d heap=%0d",
                   m_tdata[26:0], m_tuser, m_tdata[53:27]);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    alloc_word('0);
    alloc_word(FW'(52));
    alloc_word(FW'(53));
    alloc_word(FW'(500));
    free_word(FW'(HDR + 64));          // middle block
    free_word(FW'(HDR + 64));          // already free
    free_word(FW'(7));                 // never allocated
    free_word('1);
    alloc_word(FW'(10));               // reuses the hole, no split
    alloc_word(FW'(104857600));        // past the limit
    alloc_word('1);
    free_word(FW'(HDR));
    free_word(FW'(HDR + 64));
    free_word(FW'(HDR + 128));         // merges with the free block before it
    alloc_word(FW'(200));
    free_word(FW'(HDR + 128 + 65));    // frees the 500-byte block
    free_all();
  endtask

  task automatic test_limits();
    write_limit(FW'(64));
    alloc_word(FW'(52));
    alloc_word('0);
    free_all();
    write_limit(FW'(300));
    repeat (8) alloc_word(FW'($urandom_range(0, 80)));
    write_limit(FW'(64));              // below current heap end
    alloc_word(FW'(10));
    free_all();
    write_limit(FW'(104857600));
    alloc_word(FW'(104857600 - HDR));
    alloc_word('0);
    free_all();
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: alloc_word(FW'($urandom));
        1: free_word(FW'($urandom));
        2, 3, 4: alloc_word(FW'($urandom_range(0, 400)));
        default:
          if (live_users.size() != 0)
            free_word(live_users[$urandom_range(live_users.size()-1)]);
          else alloc_word(FW'($urandom_range(0, 2000)));
      endcase
    end
  endtask

  task automatic test_random();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(60);
    send_idle_pct = 83; recv_stall_pct = 0;  random_phase(50);
    write_limit(FW'($urandom_range(2000, 20000)));
    send_idle_pct = 0;  recv_stall_pct = 83; random_phase(50);
    send_idle_pct = 21; recv_stall_pct = 21; random_phase(50);
    write_limit(FW'(104857600));
    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(20);
    free_all();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_rx = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_rx = 1'b0;
      end
      repeat (10) alloc_word(FW'($urandom_range(0, 100)));
    join
    drain();                            // sender waits for every result
    free_all();
  endtask

  initial begin
    limit_reg = LIMIT_RESET;
    blk_cnt = 0;
    heap_top = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #300ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
